/* rtl/ordered_list_engine_assert.svh */
`ifndef ORDERED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_ASSERT_SVH
// Assertion helpers for the ordered list engine.
`ifndef SYNTHESIS
`define OLE_ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");
`define OLE_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");
`else
`define OLE_ASSERT_IMPLIES(label, clk, rst, cond, expr)
`define OLE_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif
`endif

/* rtl/ole_pkg.sv */
package ole_pkg;
   localparam int Capacity = 64;
   localparam int SlotW    = $clog2(Capacity + 1);
   localparam int IdxW     = $clog2(Capacity);
   localparam int PosW     = 7;
   localparam int ValW     = 32;
   localparam logic [SlotW-1:0] Nil = SlotW'(Capacity);

   typedef enum logic [3:0] {
      ACT_INS_FRONT = 4'd0,
      ACT_INS_END   = 4'd1,
      ACT_INS_AT    = 4'd2,
      ACT_READ_AT   = 4'd3,
      ACT_DEL_FRONT = 4'd4,
      ACT_DEL_END   = 4'd5,
      ACT_DEL_AT    = 4'd6,
      ACT_DEL_VALUE = 4'd7,
      ACT_SEARCH    = 4'd8
   } action_type;

   typedef enum logic [2:0] {
      MEM_NONE,
      MEM_RD_NEXT,
      MEM_RD_PREV,
      MEM_WR_NEXT,
      MEM_WR_PREV,
      MEM_WR_VAL
   } mem_op_type;

   typedef enum logic [2:0] {
      ADDR_CUR,
      ADDR_FREE,
      ADDR_PREV,
      ADDR_NEXT,
      ADDR_NEW
   } addr_sel_type;

   typedef enum logic [2:0] {
      DAT_NEXT,
      DAT_PREV,
      DAT_NEW,
      DAT_FREE,
      DAT_CUR,
      DAT_NIL
   } dat_sel_type;

   // controller -> datapath
   typedef struct packed {
      mem_op_type   op;
      addr_sel_type addr;
      dat_sel_type  dat;
      logic         load_req;
      logic         cur_head;
      logic         cur_tail;
      logic         cur_free;
      logic         cur_rd;
      logic         prev_rd;
      logic         next_rd;
      logic         new_cur;
      logic         vrd_cap;
      logic         head_set;
      dat_sel_type  head_dat;
      logic         tail_set;
      dat_sel_type  tail_dat;
      logic         free_set;
      dat_sel_type  free_dat;
      logic         cnt_inc;
      logic         cnt_dec;
      logic         step_clr;
      logic         step_inc;
      logic         rsp_load;
      logic         rsp_ok;
      logic         rsp_use_rd;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      action_type act;
      logic pos_bad_ins;
      logic pos_bad_rd;
      logic pos_is_end;
      logic walk_done;
      logic cur_nil;
      logic prev_nil;
      logic next_nil;
      logic free_nil;
      logic head_nil;
      logic tail_nil;
      logic match;
      logic steps_full;
   } sts_type;
endpackage

/* rtl/ole_datapath.sv */
module ole_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  ole_pkg::cmd_type             cmd,
   output ole_pkg::sts_type             sts,
   input  logic [3:0]                   req_action,
   input  logic [ole_pkg::PosW-1:0]     req_position,
   input  logic signed [ole_pkg::ValW-1:0] req_item_value,
   output logic                         rsp_ok,
   output logic signed [ole_pkg::ValW-1:0] rsp_result_value,
   output logic [ole_pkg::PosW-1:0]     rsp_list_count
);
   localparam int SW = ole_pkg::SlotW;
   localparam int IW = ole_pkg::IdxW;
   localparam int VW = ole_pkg::ValW;

   logic [SW-1:0] next_mem [ole_pkg::Capacity];
   logic [SW-1:0] prev_mem [ole_pkg::Capacity];
   logic [VW-1:0] val_mem  [ole_pkg::Capacity];

   logic [3:0]    act_ff;
   logic [ole_pkg::PosW-1:0] pos_ff;
   logic [VW-1:0] val_ff;
   logic [SW-1:0] cur_ff, prv_ff, nxt_ff, new_ff;
   logic [SW-1:0] head_ff, tail_ff, free_ff;
   logic [SW-1:0] head_in, tail_in, free_in;
   logic [SW:0]   cnt_ff, cnt_in;
   logic [SW:0]   step_ff;
   logic [SW-1:0] rd_link;
   logic [VW-1:0] rd_val;
   logic [SW-1:0] addr;
   logic [SW-1:0] wdat;
   logic          rsp_ok_ff;
   logic [VW-1:0] rsp_val_ff;
   logic [SW:0]   cnt1;

   // fresh-slot initialisation: slots beyond fill mark chain to next
   logic [SW:0]   fill_ff;

   function automatic logic [SW-1:0] pick(ole_pkg::dat_sel_type s, logic [SW-1:0] n,
                                          logic [SW-1:0] p, logic [SW-1:0] w,
                                          logic [SW-1:0] f, logic [SW-1:0] c);
      logic [SW-1:0] r;
      case (s)
         ole_pkg::DAT_NEXT: r = n;
         ole_pkg::DAT_PREV: r = p;
         ole_pkg::DAT_NEW:  r = w;
         ole_pkg::DAT_FREE: r = f;
         ole_pkg::DAT_CUR:  r = c;
         default:           r = ole_pkg::Nil;
      endcase
      return r;
   endfunction

   always_comb begin
      case (cmd.addr)
         ole_pkg::ADDR_CUR:  addr = cur_ff;
         ole_pkg::ADDR_FREE: addr = free_ff;
         ole_pkg::ADDR_PREV: addr = prv_ff;
         ole_pkg::ADDR_NEXT: addr = nxt_ff;
         default:            addr = new_ff;
      endcase
      wdat = pick(cmd.dat, nxt_ff, prv_ff, new_ff, free_ff, cur_ff);
   end

   // next links: entries never written read as slot+1 (free chain at reset)
   logic [SW-1:0] next_q;
   logic          seen_q;
   logic [SW-1:0] addr_q;
   logic [SW-1:0] prev_q;

   always_ff @(posedge clock) begin
      if (cmd.op == ole_pkg::MEM_WR_NEXT) next_mem[addr[IW-1:0]] <= wdat;
      if (cmd.op == ole_pkg::MEM_WR_PREV) prev_mem[addr[IW-1:0]] <= wdat;
      if (cmd.op == ole_pkg::MEM_WR_VAL)  val_mem[addr[IW-1:0]]  <= val_ff;
      next_q <= next_mem[addr[IW-1:0]];
      prev_q <= prev_mem[addr[IW-1:0]];
      rd_val <= val_mem[addr[IW-1:0]];
      addr_q <= addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (cmd.op == ole_pkg::MEM_WR_NEXT && {1'b0, addr} >= fill_ff) begin
         fill_ff <= {1'b0, addr} + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      seen_q <= ({1'b0, addr} < fill_ff);
   end

   always_comb begin
      if (seen_q) rd_link = next_q;
      else        rd_link = addr_q + 1'b1;
   end

   assign cnt1 = cnt_ff + 1'b1;

   always_comb begin
      head_in = cmd.head_set ? pick(cmd.head_dat, nxt_ff, prv_ff, new_ff, free_ff, cur_ff)
                             : head_ff;
      tail_in = cmd.tail_set ? pick(cmd.tail_dat, nxt_ff, prv_ff, new_ff, free_ff, cur_ff)
                             : tail_ff;
      free_in = cmd.free_set ? pick(cmd.free_dat, nxt_ff, prv_ff, new_ff, free_ff, cur_ff)
                             : free_ff;
      cnt_in  = cnt_ff;
      if (cmd.cnt_inc) cnt_in = cnt1;
      if (cmd.cnt_dec) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= ole_pkg::Nil;
         tail_ff   <= ole_pkg::Nil;
         free_ff   <= '0;
         cnt_ff    <= '0;
         rsp_ok_ff <= 1'b0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         free_ff <= free_in;
         cnt_ff  <= cnt_in;
         if (cmd.rsp_load) rsp_ok_ff <= cmd.rsp_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         act_ff <= req_action;
         pos_ff <= req_position;
         val_ff <= req_item_value;
      end
      if (cmd.cur_head) cur_ff <= head_ff;
      if (cmd.cur_tail) cur_ff <= tail_ff;
      if (cmd.cur_free) cur_ff <= free_ff;
      if (cmd.cur_rd)   cur_ff <= rd_link;
      if (cmd.new_cur)  new_ff <= cur_ff;
      if (cmd.prev_rd)  prv_ff <= prev_q;
      if (cmd.next_rd)  nxt_ff <= rd_link;
      if (cmd.step_clr) step_ff <= {{SW{1'b0}}, 1'b1};
      else if (cmd.step_inc) step_ff <= step_ff + 1'b1;
      if (cmd.vrd_cap)  rsp_val_ff <= rd_val;
      if (cmd.rsp_load) rsp_val_ff <= !cmd.rsp_ok ? '1 :
                                      (cmd.rsp_use_rd ? rsp_val_ff : val_ff);
   end

   always_comb begin
      sts.act         = ole_pkg::action_type'(act_ff);
      sts.pos_bad_ins = (pos_ff == '0) || ({1'b0, pos_ff} > {1'b0, cnt1[ole_pkg::PosW-1:0]})
                        || (cnt1 > (SW+1)'(ole_pkg::Capacity + 1));
      sts.pos_bad_rd  = (pos_ff == '0) || ({1'b0, pos_ff} > {1'b0, cnt_ff[ole_pkg::PosW-1:0]});
      sts.pos_is_end  = ({1'b0, pos_ff} == {1'b0, cnt1[ole_pkg::PosW-1:0]});
      sts.walk_done   = (step_ff >= {{(SW+1-ole_pkg::PosW){1'b0}}, pos_ff});
      sts.cur_nil     = (cur_ff == ole_pkg::Nil);
      sts.prev_nil    = (prv_ff == ole_pkg::Nil);
      sts.next_nil    = (nxt_ff == ole_pkg::Nil);
      sts.free_nil    = (free_ff == ole_pkg::Nil);
      sts.head_nil    = (head_ff == ole_pkg::Nil);
      sts.tail_nil    = (tail_ff == ole_pkg::Nil);
      sts.match       = (rd_val == val_ff);
      sts.steps_full  = (step_ff > (SW+1)'(ole_pkg::Capacity));
   end

   assign rsp_ok           = rsp_ok_ff;
   assign rsp_result_value = rsp_val_ff;
   assign rsp_list_count   = cnt_ff[ole_pkg::PosW-1:0];
endmodule

/* rtl/ole_controller.sv */
module ole_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  ole_pkg::sts_type sts,
   output ole_pkg::cmd_type cmd
);
   typedef enum logic [4:0] {
      S_IDLE, S_DECODE,
      S_INS_TAKE, S_INS_TAKE_W, S_INS_VAL, S_INS_POS, S_INS_LINK,
      S_INS_RDP, S_INS_RDP_W, S_INS_WNX, S_INS_WPV, S_INS_WBN, S_INS_WAP,
      S_WALK_RD, S_WALK_W, S_READ_V, S_READ_VW,
      S_UNL_RD, S_UNL_RDW, S_UNL_A, S_UNL_B, S_UNL_FREE,
      S_FIND_RD, S_FIND_W, S_RESP, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      pend_ff, pend_in;
   logic      rv_ff, rv_in;

   always_comb begin
      cmd      = '0;
      cmd.op   = ole_pkg::MEM_NONE;
      cmd.addr = ole_pkg::ADDR_CUR;
      cmd.dat  = ole_pkg::DAT_NIL;
      cmd.head_dat = ole_pkg::DAT_NIL;
      cmd.tail_dat = ole_pkg::DAT_NIL;
      cmd.free_dat = ole_pkg::DAT_NIL;
      state_in = state_ff;
      pend_in  = pend_ff;
      rv_in    = rv_ff;
      req_ready = (state_ff == S_IDLE) && !rv_ff;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      case (state_ff)
         S_IDLE: if (req_valid && req_ready) begin
            cmd.load_req = 1'b1;
            state_in = S_DECODE;
         end
         S_DECODE: begin
            cmd.step_clr = 1'b1;
            case (sts.act)
               ole_pkg::ACT_INS_FRONT, ole_pkg::ACT_INS_END, ole_pkg::ACT_INS_AT: begin
                  if ((sts.act == ole_pkg::ACT_INS_AT && sts.pos_bad_ins) || sts.free_nil)
                     state_in = S_RESP;
                  else state_in = S_INS_TAKE;
                  pend_in = 1'b0;
                  cmd.cur_free = 1'b1;
               end
               ole_pkg::ACT_READ_AT, ole_pkg::ACT_DEL_AT: begin
                  cmd.cur_head = 1'b1;
                  pend_in = 1'b0;
                  state_in = sts.pos_bad_rd ? S_RESP : S_WALK_RD;
               end
               ole_pkg::ACT_DEL_FRONT: begin
                  cmd.cur_head = 1'b1;
                  pend_in = 1'b0;
                  state_in = sts.head_nil ? S_RESP : S_UNL_RD;
               end
               ole_pkg::ACT_DEL_END: begin
                  cmd.cur_tail = 1'b1;
                  pend_in = 1'b0;
                  state_in = sts.tail_nil ? S_RESP : S_UNL_RD;
               end
               ole_pkg::ACT_DEL_VALUE, ole_pkg::ACT_SEARCH: begin
                  cmd.cur_head = 1'b1;
                  pend_in = 1'b0;
                  state_in = S_FIND_RD;
               end
               default: begin
                  pend_in = 1'b0;
                  state_in = S_RESP;
               end
            endcase
         end
         // take free slot: free_head <= next[cur]
         S_INS_TAKE: begin
            cmd.addr = ole_pkg::ADDR_CUR;
            cmd.new_cur = 1'b1;
            state_in = S_INS_TAKE_W;
         end
         S_INS_TAKE_W: begin
            cmd.next_rd = 1'b1;
            state_in = S_INS_VAL;
         end
         S_INS_VAL: begin
            cmd.op = ole_pkg::MEM_WR_VAL;
            cmd.addr = ole_pkg::ADDR_NEW;
            cmd.free_set = 1'b1;
            cmd.free_dat = ole_pkg::DAT_NEXT;
            cmd.cur_head = (sts.act == ole_pkg::ACT_INS_FRONT) ||
                           (sts.act == ole_pkg::ACT_INS_AT && !sts.pos_is_end);
            cmd.cur_tail = !cmd.cur_head;
            state_in = (sts.act == ole_pkg::ACT_INS_AT && !sts.pos_is_end) ?
                       S_INS_POS : S_INS_LINK;
         end
         S_INS_POS: begin
            if (sts.walk_done) state_in = S_INS_LINK;
            else begin
               cmd.addr = ole_pkg::ADDR_CUR;
               state_in = S_INS_RDP;
               pend_in = 1'b1;
            end
         end
         S_INS_RDP: begin
            cmd.addr = ole_pkg::ADDR_CUR;
            state_in = S_INS_RDP_W;
         end
         S_INS_RDP_W: begin
            cmd.cur_rd = 1'b1;
            cmd.step_inc = 1'b1;
            state_in = S_INS_POS;
         end
         // after: end-insert uses cur=tail as 'before', else cur is 'after'
         S_INS_LINK: begin
            cmd.addr = ole_pkg::ADDR_CUR;
            state_in = S_INS_WNX;
            if (sts.act == ole_pkg::ACT_INS_END ||
                (sts.act == ole_pkg::ACT_INS_AT && sts.pos_is_end)) begin
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
         end
         S_INS_WNX: begin
            cmd.prev_rd = 1'b1;
            cmd.op = ole_pkg::MEM_WR_NEXT;
            cmd.addr = ole_pkg::ADDR_NEW;
            if (pend_ff) cmd.dat = ole_pkg::DAT_NIL;
            else         cmd.dat = ole_pkg::DAT_CUR;
            state_in = S_INS_WPV;
         end
         S_INS_WPV: begin
            cmd.op = ole_pkg::MEM_WR_PREV;
            cmd.addr = ole_pkg::ADDR_NEW;
            if (pend_ff)          cmd.dat = ole_pkg::DAT_CUR;
            else if (sts.cur_nil) cmd.dat = ole_pkg::DAT_NIL;
            else                  cmd.dat = ole_pkg::DAT_PREV;
            state_in = S_INS_WBN;
         end
         S_INS_WBN: begin
            if (sts.cur_nil || (!pend_ff && sts.prev_nil)) begin
               cmd.head_set = 1'b1;
               cmd.head_dat = ole_pkg::DAT_NEW;
            end else begin
               cmd.op = ole_pkg::MEM_WR_NEXT;
               if (pend_ff) cmd.addr = ole_pkg::ADDR_CUR;
               else         cmd.addr = ole_pkg::ADDR_PREV;
               cmd.dat = ole_pkg::DAT_NEW;
            end
            state_in = S_INS_WAP;
         end
         S_INS_WAP: begin
            if (pend_ff || sts.cur_nil) begin
               cmd.tail_set = 1'b1;
               cmd.tail_dat = ole_pkg::DAT_NEW;
            end else begin
               cmd.op = ole_pkg::MEM_WR_PREV;
               cmd.addr = ole_pkg::ADDR_CUR;
               cmd.dat = ole_pkg::DAT_NEW;
            end
            state_in = S_UNL_FREE;
         end
         S_WALK_RD: begin
            if (sts.walk_done) begin
               state_in = (sts.act == ole_pkg::ACT_READ_AT) ? S_READ_V : S_UNL_RD;
            end else begin
               cmd.addr = ole_pkg::ADDR_CUR;
               state_in = S_WALK_W;
            end
         end
         S_WALK_W: begin
            cmd.cur_rd = 1'b1;
            cmd.step_inc = 1'b1;
            state_in = S_WALK_RD;
         end
         S_READ_V: begin
            cmd.addr = ole_pkg::ADDR_CUR;
            state_in = S_READ_VW;
         end
         S_READ_VW: begin
            cmd.vrd_cap = 1'b1;
            pend_in = 1'b1;
            state_in = S_RESP;
         end
         S_UNL_RD: begin
            cmd.addr = ole_pkg::ADDR_CUR;
            state_in = S_UNL_RDW;
         end
         S_UNL_RDW: begin
            cmd.prev_rd = 1'b1;
            cmd.next_rd = 1'b1;
            cmd.vrd_cap = 1'b1;
            state_in = S_UNL_A;
         end
         S_UNL_A: begin
            if (sts.prev_nil) begin
               cmd.head_set = 1'b1;
               cmd.head_dat = ole_pkg::DAT_NEXT;
            end else begin
               cmd.op = ole_pkg::MEM_WR_NEXT;
               cmd.addr = ole_pkg::ADDR_PREV;
               cmd.dat = ole_pkg::DAT_NEXT;
            end
            state_in = S_UNL_B;
         end
         S_UNL_B: begin
            if (sts.next_nil) begin
               cmd.tail_set = 1'b1;
               cmd.tail_dat = ole_pkg::DAT_PREV;
            end else begin
               cmd.op = ole_pkg::MEM_WR_PREV;
               cmd.addr = ole_pkg::ADDR_NEXT;
               cmd.dat = ole_pkg::DAT_PREV;
            end
            cmd.cnt_dec = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            // return slot to free chain
            cmd.op = ole_pkg::MEM_WR_NEXT;
            cmd.addr = ole_pkg::ADDR_CUR;
            cmd.dat = ole_pkg::DAT_FREE;
            cmd.free_set = 1'b1;
            cmd.free_dat = ole_pkg::DAT_CUR;
            pend_in = 1'b1;
            state_in = S_RESP;
         end
         S_UNL_FREE: begin
            cmd.cnt_inc = 1'b1;
            pend_in = 1'b0;
            cmd.rsp_load = 1'b1;
            cmd.rsp_ok = 1'b1;
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         S_FIND_RD: begin
            if (sts.cur_nil || sts.steps_full) begin
               state_in = S_RESP;
               pend_in = 1'b0;
            end else begin
               cmd.addr = ole_pkg::ADDR_CUR;
               state_in = S_FIND_W;
            end
         end
         S_FIND_W: begin
            cmd.vrd_cap = 1'b1;
            if (sts.match) begin
               if (sts.act == ole_pkg::ACT_SEARCH) begin
                  pend_in = 1'b1;
                  cmd.rsp_use_rd = 1'b0;
                  state_in = S_RESP;
               end else begin
                  state_in = S_UNL_RD;
               end
            end else begin
               cmd.cur_rd = 1'b1;
               cmd.step_inc = 1'b1;
               state_in = S_FIND_RD;
            end
         end
         S_RESP: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_ok = pend_ff;
            cmd.rsp_use_rd = (sts.act != ole_pkg::ACT_SEARCH);
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         rv_ff    <= rv_in;
      end
   end

   assign rsp_valid = rv_ff;
endmodule

/* rtl/ordered_list_engine.sv */
// Ordered list of up to 64 signed 32-bit values kept as a doubly linked chain in
// slot stores with registered reads, with unused slots on a free chain. One
// request, one response; a new request is taken in the cycle after the response
// is accepted. A request that fails its checks at once (bad position, full store,
// read or front/end delete on an empty list, unused action) is answered without
// walking the chain. A read or delete at position P walks P-1 links from the
// head, and an insert at position P short of the end walks as many; a search or
// delete by value compares one slot at a time from the head until a match or the
// end of the list.
`include "ordered_list_engine_assert.svh"
module ordered_list_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [3:0]                    req_action,
   input  logic [ole_pkg::PosW-1:0]      req_position,
   input  logic signed [ole_pkg::ValW-1:0] req_item_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_ok,
   output logic signed [ole_pkg::ValW-1:0] rsp_result_value,
   output logic [ole_pkg::PosW-1:0]      rsp_list_count
);
   ole_pkg::cmd_type cmd;
   ole_pkg::sts_type sts;

   ole_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ole_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_action       (req_action),
      .req_position     (req_position),
      .req_item_value   (req_item_value),
      .rsp_ok           (rsp_ok),
      .rsp_result_value (rsp_result_value),
      .rsp_list_count   (rsp_list_count)
   );

   `OLE_ASSERT_IMPLIES(a_no_accept_busy, clock, reset, rsp_valid, !req_ready)
   `OLE_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1,
      rsp_list_count <= ole_pkg::PosW'(ole_pkg::Capacity))
   `OLE_ASSERT_IMPLIES(a_fail_value, clock, reset, rsp_valid && !rsp_ok,
      rsp_result_value == '1)
   `OLE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_result_value) && $stable(rsp_list_count))
endmodule
